// File: rtl/core/temperature_seven_segment_display_unit_defines.svh
// Assertion macros for the checker file of the display unit.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef TEMPERATURE_SEVEN_SEGMENT_DISPLAY_UNIT_DEFINES_SVH
`define TEMPERATURE_SEVEN_SEGMENT_DISPLAY_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TSSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("display unit check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TSSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("display unit check failed");

`endif

// File: rtl/core/tssd_pkg.sv
`timescale 1ns / 1ps
package tssd_pkg;

  localparam int NUM_DIGITS  = 8;
  localparam int SCAN_W      = $clog2(NUM_DIGITS);
  localparam int DIGIT_W     = 4;
  localparam int CONV_DIGITS = 6;
  localparam int PERIOD_W    = 16;
  localparam int RAW_W       = 16;
  localparam int SEG_W       = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd200;
  localparam logic [DIGIT_W-1:0]  CODE_MINUS   = 4'd10;
  localparam logic [DIGIT_W-1:0]  CODE_BLANK   = 4'd11;
  localparam logic [SCAN_W-1:0]   DOT_DIGIT    = 3'd3;
  localparam logic [SEG_W-1:0]    DOT_MASK     = 8'h80;

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic signed [RAW_W-1:0]  raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0] digit_select;
    logic [SEG_W-1:0]      segments;
    logic                  sample_request;
  } out_item_t;

  // Registered input item with the sample already converted to digit codes.
  // digits[k] is the code for display digit k + 2.
  typedef struct packed {
    opcode_t                                opcode;
    logic                                   minus;
    logic [CONV_DIGITS-1:0][DIGIT_W-1:0]    digits;
  } stage_t;

  // Fraction f (sixteenths) times 625 as four BCD digits.
  function automatic logic [15:0] build_frac_entry(input int f);
    int v;
    v = f * 625;
    return {4'((v / 1000) % 10), 4'((v / 100) % 10), 4'((v / 10) % 10), 4'(v % 10)};
  endfunction

  // Low byte of the whole degrees, modulo 100, as two BCD digits.
  function automatic logic [7:0] build_low_entry(input int b);
    return {4'((b % 100) / 10), 4'(b % 10)};
  endfunction

  // High bits of the whole degrees (weight 256), modulo 100, as two BCD digits.
  function automatic logic [7:0] build_high_entry(input int a);
    int v;
    v = (a * 256) % 100;
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic logic [15:0] frac_lookup(input logic [3:0] f);
    logic [15:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (f == 4'(k)) r = build_frac_entry(k);
    end
    return r;
  endfunction

  function automatic logic [7:0] low_lookup(input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      if (b == 8'(k)) r = build_low_entry(k);
    end
    return r;
  endfunction

  function automatic logic [7:0] high_lookup(input logic [4:0] a);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      if (a == 5'(k)) r = build_high_entry(k);
    end
    return r;
  endfunction

  function automatic logic [SEG_W-1:0] seg_of_code(input logic [DIGIT_W-1:0] code);
    logic [SEG_W-1:0] s;
    unique case (code)
      4'd0:       s = 8'h3f;
      4'd1:       s = 8'h06;
      4'd2:       s = 8'h5b;
      4'd3:       s = 8'h4f;
      4'd4:       s = 8'h66;
      4'd5:       s = 8'h6d;
      4'd6:       s = 8'h7d;
      4'd7:       s = 8'h07;
      4'd8:       s = 8'h7f;
      4'd9:       s = 8'h6f;
      CODE_MINUS: s = 8'h40;
      default:    s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/tssd_sample_conv.sv
`timescale 1ns / 1ps
module tssd_sample_conv (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  tssd_pkg::in_item_t item,
  input  logic              advance,
  output logic              item_stall,
  output logic              stage_valid,
  output tssd_pkg::stage_t  stage
);
  import tssd_pkg::*;

  logic                   take;
  logic                   minus;
  logic [RAW_W:0]         mag;
  logic [7:0]             low_bcd;
  logic [7:0]             high_bcd;
  logic [15:0]            frac_bcd;
  logic [4:0]             units_sum;
  logic                   units_carry;
  logic [3:0]             units_digit;
  logic [4:0]             tens_sum;
  logic [3:0]             tens_digit;
  stage_t                 stage_next;

  assign item_stall = stage_valid & ~advance;
  assign take       = item_valid & ~item_stall;

  // Magnitude needs one bit more than the reading to hold the most negative value.
  assign minus = item.raw_temperature[RAW_W-1];
  assign mag   = minus ? (RAW_W+1)'(-{item.raw_temperature[RAW_W-1], item.raw_temperature})
                       : {1'b0, item.raw_temperature};

  // Whole degrees modulo 100 from two table halves and one BCD addition.
  assign low_bcd  = low_lookup(mag[11:4]);
  assign high_bcd = high_lookup(mag[16:12]);
  assign frac_bcd = frac_lookup(mag[3:0]);

  assign units_sum   = 5'(low_bcd[3:0]) + 5'(high_bcd[3:0]);
  assign units_carry = units_sum > 5'd9;
  assign units_digit = units_carry ? 4'(units_sum - 5'd10) : units_sum[3:0];
  assign tens_sum    = 5'(low_bcd[7:4]) + 5'(high_bcd[7:4]) + 5'(units_carry);
  assign tens_digit  = (tens_sum > 5'd9) ? 4'(tens_sum - 5'd10) : tens_sum[3:0];

  always_comb begin
    stage_next.opcode    = item.opcode;
    stage_next.minus     = minus;
    stage_next.digits[0] = tens_digit;
    stage_next.digits[1] = units_digit;
    stage_next.digits[2] = frac_bcd[15:12];
    stage_next.digits[3] = frac_bcd[11:8];
    stage_next.digits[4] = frac_bcd[7:4];
    stage_next.digits[5] = frac_bcd[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
    if (take) begin
      stage <= stage_next;
    end
  end

endmodule

// File: rtl/core/tssd_scan.sv
`timescale 1ns / 1ps
module tssd_scan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  tssd_pkg::stage_t                  stage,
  input  logic                              cfg_write,
  input  logic [tssd_pkg::PERIOD_W-1:0]     cfg_data,
  output tssd_pkg::out_item_t               result_next
);
  import tssd_pkg::*;

  logic [PERIOD_W-1:0] sample_period;
  logic [SCAN_W-1:0]   scan_position;
  logic [PERIOD_W-1:0] tick_count;
  logic [DIGIT_W-1:0]  digit_codes [NUM_DIGITS];
  logic [PERIOD_W-1:0] tick_inc;
  logic                request;
  logic [SEG_W-1:0]    seg;
  logic                do_tick;
  logic                do_sample;

  assign do_tick   = advance & (stage.opcode == OP_TICK);
  assign do_sample = advance & (stage.opcode == OP_SAMPLE);

  assign tick_inc = tick_count + 1'b1;
  assign request  = tick_inc == sample_period;

  always_comb begin
    seg = seg_of_code(digit_codes[scan_position]);
    if (scan_position == DOT_DIGIT) seg = seg | DOT_MASK;
    unique case (stage.opcode)
      OP_TICK: begin
        result_next.digit_select   = ~(NUM_DIGITS'(1) << scan_position);
        result_next.segments       = seg;
        result_next.sample_request = request;
      end
      OP_SAMPLE: begin
        result_next.digit_select   = '1;
        result_next.segments       = '0;
        result_next.sample_request = 1'b0;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
      scan_position <= '0;
      tick_count    <= '0;
      for (int k = 0; k < NUM_DIGITS; k++) begin
        digit_codes[k] <= (k < 3) ? CODE_BLANK : '0;
      end
    end else begin
      if (cfg_write) begin
        sample_period <= cfg_data;
      end
      if (do_tick) begin
        scan_position <= scan_position + 1'b1;
        tick_count    <= request ? '0 : tick_inc;
      end
      if (do_sample) begin
        digit_codes[0] <= stage.minus ? CODE_MINUS : CODE_BLANK;
        digit_codes[1] <= CODE_BLANK;
        for (int k = 2; k < NUM_DIGITS; k++) begin
          digit_codes[k] <= stage.digits[k-2];
        end
      end
    end
  end

endmodule

// File: rtl/core/temperature_seven_segment_display_unit.sv
`timescale 1ns / 1ps
// Eight-digit multiplexed seven-segment temperature display.
//
// Items arrive on the item channel (item_valid / item_stall / item). A tick
// item drives the next digit of the scan and counts towards a sample request;
// a sample item loads a new reading, in sixteenths of a degree, into the
// digit store. Every item produces exactly one result on the result channel
// (result_valid / result_stall / result); a sample gives an all-off result.
// A transfer takes place on a rising edge with valid high and stall low.
//
// An item passes two registers before its result is shown: the input
// register, where the reading is converted to decimal digits, and the
// result register. Throughput is one item per cycle while the receiver does
// not stall, set by the single pass through the scan logic between them.
// When the receiver stalls, the result register holds its contents and the
// input register still accepts one more item; only once both are full does
// item_stall rise. The sample period is written over the cfg channel, which
// is always ready and should only be used while the unit is idle.
// Reset empties both registers, returns the period to 200 ticks, the scan
// and tick counter to zero, and shows three blanks followed by five zeros.
module temperature_seven_segment_display_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  tssd_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output tssd_pkg::out_item_t           result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tssd_pkg::PERIOD_W-1:0] cfg_data
);
  import tssd_pkg::*;

  logic      stage_valid;
  stage_t    stage;
  logic      advance;
  out_item_t result_next;

  // The converted item moves on whenever the result register is empty or
  // its current contents are being transferred out this cycle.
  assign advance   = stage_valid & (~result_valid | ~result_stall);
  assign cfg_ready = 1'b1;

  tssd_sample_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .advance     (advance),
    .item_stall  (item_stall),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  tssd_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .stage       (stage),
    .cfg_write   (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .result_next (result_next)
  );

  // Result register: loaded on advance, emptied once its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/core/tssd_checker.sv
`timescale 1ns / 1ps
`include "temperature_seven_segment_display_unit_defines.svh"
module tssd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          result_valid,
  input logic                          result_stall,
  input tssd_pkg::out_item_t           result
);
  import tssd_pkg::*;

  // A stalled result stays put.
  `TSSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                    result_valid && $stable(result))

  // An all-off select only comes from a sample, which lights nothing.
  `TSSD_ASSERT_NOW(a_sample_dark, result_valid && (result.digit_select == '1),
                   (result.segments == '0) && !result.sample_request)

  // A tick drives exactly one digit.
  `TSSD_ASSERT_NOW(a_one_digit, result_valid && (result.digit_select != '1),
                   $onehot(~result.digit_select))

  // The decimal point is lit on the dot digit and nowhere else.
  `TSSD_ASSERT_NOW(a_dot_place, result_valid,
                   result.segments[SEG_W-1] == !result.digit_select[DOT_DIGIT])

endmodule

bind temperature_seven_segment_display_unit tssd_checker u_tssd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: test/temperature_seven_segment_display_unit_tb.sv
`timescale 1ns / 1ps
module temperature_seven_segment_display_unit_tb;
  import tssd_pkg::*;

  // Segment patterns indexed by digit code. Codes 0 to 9 are the decimal
  // digits, the minus code lights segment g only, and the blank code and
  // the unused codes above it leave every segment dark.
  localparam logic [15:0][7:0] GLYPHS = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h40, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };

  // Generous ceiling on the run length in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Keeps its own image of the display: the scan position, the tick
  // counter, the eight digit codes and the sample period. Each accepted
  // input transfer is turned into the frame the unit should show, and the
  // frames wait in arrival order until the matching result transfer comes.
  class display_scoreboard;
    logic [15:0]     period;
    logic [2:0]      scan;
    logic [15:0]     ticks;
    logic [3:0]      codes [8];
    out_item_t       frames [$];
    int unsigned     failures;

    function new();
      period   = PERIOD_RESET;
      scan     = '0;
      ticks    = '0;
      failures = 0;
      foreach (codes[k]) codes[k] = (k < 3) ? CODE_BLANK : 4'd0;
    endfunction

    function void write_period(logic [15:0] value);
      period = value;
    endfunction

    function void note_item(in_item_t it);
      out_item_t   frame;
      logic [15:0] bits;
      int unsigned reading;
      bit          negative;
      bits = it.raw_temperature;
      if (it.opcode == OP_TICK) begin
        frame.digit_select = ~(8'b1 << scan);
        frame.segments     = GLYPHS[codes[scan]];
        if (scan == DOT_DIGIT) frame.segments = frame.segments | DOT_MASK;
        scan  = scan + 3'd1;
        ticks = ticks + 16'd1;
        frame.sample_request = (ticks == period);
        if (frame.sample_request) ticks = '0;
      end else begin
        // The magnitude of the most negative reading needs the 17th bit.
        negative = bits[15];
        reading  = negative ? (32'd65536 - 32'(bits)) : 32'(bits);
        reading  = reading * 625;
        codes[0] = negative ? CODE_MINUS : CODE_BLANK;
        for (int k = 7; k > 1; k--) begin
          codes[k] = 4'(reading % 10);
          reading  = reading / 10;
        end
        frame.digit_select   = 8'hff;
        frame.segments       = 8'h00;
        frame.sample_request = 1'b0;
      end
      frames.push_back(frame);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (frames.size() == 0) begin
        $display("%0t: result %h with no frame expected", $time, got);
        failures++;
        return;
      end
      want = frames.pop_front();
      if (got.digit_select !== want.digit_select) begin
        $display("%0t: digit_select expected %h, got %h", $time,
                 want.digit_select, got.digit_select);
        failures++;
      end
      if (got.segments !== want.segments) begin
        $display("%0t: segments expected %h, got %h", $time,
                 want.segments, got.segments);
        failures++;
      end
      if (got.sample_request !== want.sample_request) begin
        $display("%0t: sample_request expected %b, got %b", $time,
                 want.sample_request, got.sample_request);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  in_item_t    item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls; the stimulus changes them from one phase to the next.
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycles = 0;

  display_scoreboard board;

  temperature_seven_segment_display_unit uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both channels are watched at the clock edge, where the values seen are
  // those from before the edge, so a transfer is recorded exactly once and
  // the order of processes within the time step does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.note_item(item);
      if (result_valid && !result_stall) board.check_result(result);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(opcode_t op, logic [15:0] raw);
    in_item_t it;
    it.opcode          = op;
    it.raw_temperature = raw;
    return it;
  endfunction

  // Mostly ticks, so that the scan and the request counter keep moving,
  // with a steady share of readings. The reading field of a tick carries
  // noise, which the unit must ignore.
  function automatic in_item_t random_item();
    logic [15:0] raw;
    raw = 16'($urandom);
    if ($urandom_range(99) < 82) return make_item(OP_TICK, raw);
    case ($urandom_range(15))
      0:       raw = 16'h8000;
      1:       raw = 16'h7fff;
      2:       raw = 16'h0000;
      3:       raw = 16'hffff;
      4:       raw = 16'($urandom_range(2047));
      5:       raw = -16'($urandom_range(880));
      default: ;
    endcase
    return make_item(OP_SAMPLE, raw);
  endfunction

  // Presents one item, after the random idle cycles of the current phase,
  // and returns at the edge where its transfer takes place. Valid is left
  // high so that back-to-back items need no second assignment in a step.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      item       <= make_item(OP_SAMPLE, 16'($urandom));
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
  endtask

  // Stops the item stream and waits until every frame has come out, and
  // then for the pipeline depth, so the unit is idle.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_period(value);
    cfg_valid <= 1'b0;
    cfg_data  <= 16'($urandom);
  endtask

  // A new period at or below the running count would hold back requests
  // for a full wrap of the counter. To keep requests coming, the count is
  // first brought back to zero by one request at the next tick.
  task automatic align_period(input logic [15:0] value);
    if (value <= board.ticks) begin
      write_period(board.ticks + 16'd1);
      send_item(make_item(OP_TICK, 16'($urandom)));
      settle();
    end
    write_period(value);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_item(random_item());
    settle();
  endtask

  task automatic set_pressure(input int phase);
    case (phase % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 60; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 60; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  logic [15:0] periods [8] = '{16'd1, 16'd9, 16'd200, 16'd65535,
                               16'd2, 16'd37, 16'd1, 16'd5};

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset period. A full scan of the reset display
    // shows three blanks and five zeros, with the dot on digit 3.
    for (int k = 0; k < 8; k++) send_item(make_item(OP_TICK, 16'hffff));
    // The most negative reading, whose magnitude needs a seventeenth bit.
    send_item(make_item(OP_SAMPLE, 16'h8000));
    for (int k = 0; k < 8; k++) send_item(make_item(OP_TICK, 16'h0000));
    // Largest positive reading, minus one sixteenth, alternating bit
    // patterns of both signs, one hundred degrees (its hundreds digit is
    // lost), zero, minus one degree and one sixteenth.
    send_item(make_item(OP_SAMPLE, 16'h7fff));
    send_item(make_item(OP_SAMPLE, 16'hffff));
    send_item(make_item(OP_SAMPLE, 16'h5555));
    send_item(make_item(OP_SAMPLE, 16'haaaa));
    send_item(make_item(OP_SAMPLE, 16'd1600));
    send_item(make_item(OP_SAMPLE, 16'h0000));
    send_item(make_item(OP_SAMPLE, 16'hfff0));
    send_item(make_item(OP_SAMPLE, 16'h0001));
    settle();

    // Random phases, each at its own period and with its own idling.
    for (int phase = 0; phase < 8; phase++) begin
      set_pressure(phase);
      align_period(periods[phase]);
      run_random(110);
    end

    // A period written below the running count: no request comes until
    // the counter wraps. Then a period of zero, which behaves alike.
    set_pressure(2);
    align_period(16'd1000);
    run_random(60);
    set_pressure(1);
    write_period(16'd3);
    run_random(60);
    set_pressure(0);
    write_period(16'd0);
    run_random(60);

    settle();
    repeat (8) @(posedge clk);
    if (board.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
